>>> rtl/ztsc_pkg.sv
// Shared types, command codes, initial keys and key arithmetic for the
// traditional ZIP stream cipher. No dependencies; unused by ztsc_keystream.
`default_nettype none

package ztsc_pkg;

    // Command codes carried on the input channel.
    localparam logic [1:0] CMD_RESTART  = 2'd0;
    localparam logic [1:0] CMD_PASSWORD = 2'd1;
    localparam logic [1:0] CMD_ENCRYPT  = 2'd2;
    localparam logic [1:0] CMD_DECRYPT  = 2'd3;

    // Initial key values loaded by reset and by the restart command.
    localparam logic [31:0] KEY0_INIT = 32'h1234_5678;
    localparam logic [31:0] KEY1_INIT = 32'h2345_6789;
    localparam logic [31:0] KEY2_INIT = 32'h3456_7890;

    // Reflected CRC-32 polynomial.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // The three cipher keys as one bundle.
    typedef struct packed {
        logic [31:0] crc_key;
        logic [31:0] lcg_key;
        logic [31:0] stream_key;
    } t_keys;

    localparam t_keys KEYS_INIT = '{crc_key: KEY0_INIT, lcg_key: KEY1_INIT,
                                    stream_key: KEY2_INIT};

    // One CRC-32 byte step. The eight shifts reduce to a fixed XOR network,
    // the same content as the usual 256-entry table.
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [7:0]  b);
        logic [31:0] v;
        v = {24'd0, crc[7:0] ^ b};
        for (int s = 0; s < 8; s++) begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
        end
        return v ^ (crc >> 8);
    endfunction

    // Multiply by 134775813 (0x08088405) modulo 2^32 as a sum of shifts.
    function automatic logic [31:0] lcg_mul(input logic [31:0] x);
        return (x << 27) + (x << 19) + (x << 15) + (x << 10) + (x << 2) + x;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ztsc_keystream.sv
// Keystream byte generator: bits 15..8 of t*(t^1), t = stream key low half | 2.
// Uses none of the ztsc_pkg items; no dependencies.
`default_nettype none

module ztsc_keystream (
    input  wire logic [31:0] i_stream_key,
    output logic      [7:0]  o_ks_byte
);

    logic [15:0] t;
    logic [15:0] prod;

    // Only the low 16 bits of the product are needed.
    assign t         = {i_stream_key[15:2], 1'b1, i_stream_key[0]};
    assign prod      = t * (t ^ 16'd1);
    assign o_ks_byte = prod[15:8];

endmodule

`default_nettype wire

>>> rtl/ztsc_key_update.sv
// Key update for one plaintext byte: CRC step, LCG step, CRC step.
// Depends on ztsc_pkg for t_keys, crc_byte_step and lcg_mul.
`default_nettype none

module ztsc_key_update (
    input  wire ztsc_pkg::t_keys i_keys,
    input  wire logic [7:0]      i_plain,
    output ztsc_pkg::t_keys      o_keys
);

    logic [31:0] crc_next;
    logic [31:0] lcg_sum;
    logic [31:0] lcg_next;

    assign crc_next = ztsc_pkg::crc_byte_step(i_keys.crc_key, i_plain);
    assign lcg_sum  = i_keys.lcg_key + {24'd0, crc_next[7:0]};
    assign lcg_next = ztsc_pkg::lcg_mul(lcg_sum) + 32'd1;

    assign o_keys.crc_key    = crc_next;
    assign o_keys.lcg_key    = lcg_next;
    assign o_keys.stream_key = ztsc_pkg::crc_byte_step(i_keys.stream_key,
                                                       lcg_next[31:24]);

endmodule

`default_nettype wire

>>> rtl/zip_traditional_stream_cipher.sv
// Top level of the traditional ZIP byte stream cipher: input register, key
// state, output register. Depends on ztsc_pkg, ztsc_keystream, ztsc_key_update.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------
//   command | in        | i_valid / o_stall    | i_cmd[1:0], i_data_in[7:0]
//   result  | out       | o_valid / i_stall    | o_data_out[7:0]
//
// One transaction is accepted per cycle while o_stall is low. An encrypt or
// decrypt transaction passes through the input register and the output
// register to the result channel; restart and password transactions give no
// result. The per-byte key recurrence (keystream multiply, CRC step, constant
// LCG multiply, CRC step) is combinational from the key registers back to
// them, which sets the one-byte-per-cycle rate. Reset (synchronous, active low)
// empties both stages and loads the initial keys. A stalled result holds in the
// output register while the input register keeps taking work; only a second
// result behind a stalled one stalls the command channel.
`default_nettype none

module zip_traditional_stream_cipher (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // command channel
    input  wire logic       i_valid,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_data_in,
    output logic            o_stall,
    // result channel
    output logic            o_valid,
    output logic      [7:0] o_data_out,
    input  wire logic       i_stall
);

    // Input register: holds one command transaction.
    logic            r_s1_valid;
    logic [1:0]      r_s1_cmd;
    logic [7:0]      r_s1_data;

    // Key state.
    ztsc_pkg::t_keys r_keys;
    ztsc_pkg::t_keys n_keys;
    ztsc_pkg::t_keys upd_keys;

    // Output register.
    logic            r_out_valid;
    logic [7:0]      r_out_data;

    logic            s1_result;
    logic            out_free;
    logic            s1_go;
    logic            in_accept;
    logic [7:0]      ks_byte;
    logic [7:0]      xor_byte;
    logic [7:0]      plain;

    // Encrypt and decrypt are the two commands that give a result.
    assign s1_result = (r_s1_cmd == ztsc_pkg::CMD_ENCRYPT) ||
                       (r_s1_cmd == ztsc_pkg::CMD_DECRYPT);
    // The output register can take a new result if it is empty or draining.
    assign out_free  = !r_out_valid || !i_stall;
    assign s1_go     = r_s1_valid && (!s1_result || out_free);
    assign o_stall   = r_s1_valid && !s1_go;
    assign in_accept = i_valid && !o_stall;

    ztsc_keystream u_keystream (
        .i_stream_key (r_keys.stream_key),
        .o_ks_byte    (ks_byte)
    );

    assign xor_byte = r_s1_data ^ ks_byte;

    // Except on restart, the keys absorb the plaintext: the data byte itself for
    // password and encrypt, the recovered byte for decrypt.
    always_comb begin
        case (r_s1_cmd)
            ztsc_pkg::CMD_DECRYPT: plain = xor_byte;
            default:               plain = r_s1_data;
        endcase
    end

    ztsc_key_update u_key_update (
        .i_keys  (r_keys),
        .i_plain (plain),
        .o_keys  (upd_keys)
    );

    always_comb begin
        n_keys = r_keys;
        if (s1_go) begin
            unique case (r_s1_cmd)
                ztsc_pkg::CMD_RESTART: n_keys = ztsc_pkg::KEYS_INIT;
                default:               n_keys = upd_keys;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_keys      <= ztsc_pkg::KEYS_INIT;
        end else begin
            r_keys <= n_keys;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && s1_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd  <= i_cmd;
            r_s1_data <= i_data_in;
        end
        if (s1_go && s1_result) begin
            r_out_data <= xor_byte;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;

endmodule

`default_nettype wire

>>> rtl/ztsc_checker.sv
// Port-level assertions for the traditional ZIP stream cipher, bound to the
// top level. Depends on ztsc_pkg for the command codes.
`default_nettype none

module ztsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic [1:0] i_cmd,
    input wire logic [7:0] i_data_in,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic [7:0] o_data_out,
    input wire logic       i_stall
);

    // Keystream byte of the initial stream key.
    localparam logic [7:0] KS_INIT = 8'hAB;

    logic in_acc;
    logic in_has_result;
    logic out_room;

    assign in_acc        = i_valid && !o_stall;
    assign in_has_result = (i_cmd == ztsc_pkg::CMD_ENCRYPT) ||
                           (i_cmd == ztsc_pkg::CMD_DECRYPT);
    assign out_room      = !o_valid || !i_stall;

    // The command side only stalls behind a held result.
    a_no_stall_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_room |-> !o_stall)
        else $error("command channel stalled while the result register had room");

    // A result follows its command from the input register into the output register when the output drains.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_has_result) ##1 out_room |=> o_valid)
        else $error("result missing two cycles after an encrypt or decrypt");

    // The first encrypt after a restart uses the initial keystream byte.
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd == ztsc_pkg::CMD_RESTART)
        ##1 (in_acc && i_cmd == ztsc_pkg::CMD_ENCRYPT)
        ##1 out_room
        |=> o_data_out == ($past(i_data_in, 2) ^ KS_INIT))
        else $error("wrong ciphertext for the first byte after a restart");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_out)))
        else $error("stalled result changed or vanished");

endmodule

bind zip_traditional_stream_cipher ztsc_checker u_ztsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .i_cmd      (i_cmd),
    .i_data_in  (i_data_in),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .o_data_out (o_data_out),
    .i_stall    (i_stall)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the traditional ZIP byte stream cipher: a directed
// table, then random restart/password/crypt sequences, checked by a key predictor.
// Depends on ztsc_pkg and zip_traditional_stream_cipher.
`default_nettype none

module tb_top;

    // Longest stretch without any transaction before the run is declared hung.
    // The longest legal quiet stretch is the deliberate output hold-off below.
    localparam int STUCK_LIMIT  = 2000;
    localparam int N_ITEMS      = 1100;
    localparam int N_QUIET_TAIL = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int N_DIRECTED   = 25;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic [1:0] i_cmd;
    logic [7:0] i_data_in;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_data_out;
    logic       i_stall;

    zip_traditional_stream_cipher u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd      (i_cmd),
        .i_data_in  (i_data_in),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data_out (o_data_out),
        .i_stall    (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One row of the directed table. Where has_lit is set, the expected byte is
    // the typed-in value instead of the predictor's answer.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       has_lit;
        logic [7:0] lit;
    } t_stim_row;

    // Right after a restart the stream key is 0x34567890, which gives the
    // keystream byte 0xAB; the first rows lean on that.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ztsc_pkg::CMD_ENCRYPT,  8'h00, 1'b1, 8'hAB},   // first byte after reset
        '{ztsc_pkg::CMD_RESTART,  8'hFF, 1'b0, 8'h00},   // data ignored on restart
        '{ztsc_pkg::CMD_ENCRYPT,  8'hFF, 1'b1, 8'h54},
        '{ztsc_pkg::CMD_RESTART,  8'h00, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_DECRYPT,  8'hAB, 1'b1, 8'h00},
        '{ztsc_pkg::CMD_RESTART,  8'h5A, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_DECRYPT,  8'h00, 1'b1, 8'hAB},
        '{ztsc_pkg::CMD_PASSWORD, 8'h00, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_PASSWORD, 8'hFF, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_PASSWORD, 8'h80, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_PASSWORD, 8'h01, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_ENCRYPT,  8'h00, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_ENCRYPT,  8'hFF, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_ENCRYPT,  8'h80, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_DECRYPT,  8'h01, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_DECRYPT,  8'hFF, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_DECRYPT,  8'h00, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_RESTART,  8'hA5, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_PASSWORD, 8'h7F, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_ENCRYPT,  8'h55, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_DECRYPT,  8'hAA, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_RESTART,  8'h00, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_ENCRYPT,  8'h3C, 1'b0, 8'h00},
        '{ztsc_pkg::CMD_PASSWORD, 8'hC3, 1'b0, 8'h00},   // password byte mid-stream
        '{ztsc_pkg::CMD_DECRYPT,  8'h96, 1'b0, 8'h00}
    };

    // Side-band copy of the literal expectation, moved with the payload so the
    // acceptance monitor knows which expectation belongs to the transaction.
    logic       row_lit_en;
    logic [7:0] row_lit;

    // Predictor state: the testbench's own copy of the three keys.
    ztsc_pkg::t_keys cipher_keys = ztsc_pkg::KEYS_INIT;

    logic [7:0] pending_bytes [$];
    int         n_errors     = 0;
    int         n_accepted   = 0;
    int         n_checked    = 0;
    int         n_sent       = 0;
    int         n_by_cmd [4] = '{0, 0, 0, 0};
    int         stuck_cycles = 0;
    bit         quiet        = 1'b0;
    bit         tx_gappy     = 1'b0;

    // Bit-serial reflected CRC-32 over one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ ztsc_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // Keystream byte from the low half of the stream key.
    function automatic logic [7:0] keystream_of(input logic [31:0] skey);
        logic [15:0] t;
        logic [31:0] prod;
        t    = skey[15:0] | 16'h0002;
        prod = {16'h0, t} * {16'h0, t ^ 16'h0001};
        return prod[15:8];
    endfunction

    // Advances the predicted keys by one transaction. Returns 1 when the
    // command produces an output byte, which is then placed in dout.
    function automatic bit cipher_step(input logic [1:0] cmd, input logic [7:0] din,
                                       output logic [7:0] dout);
        logic [7:0] plain;
        dout = 8'h00;
        if (cmd == ztsc_pkg::CMD_RESTART) begin
            cipher_keys = ztsc_pkg::KEYS_INIT;
            return 1'b0;
        end
        if (cmd == ztsc_pkg::CMD_PASSWORD) begin
            plain = din;
        end else begin
            dout  = din ^ keystream_of(cipher_keys.stream_key);
            // The keys always absorb the plaintext side of the pair.
            plain = (cmd == ztsc_pkg::CMD_ENCRYPT) ? din : dout;
        end
        cipher_keys.crc_key    = crc32_byte(cipher_keys.crc_key, plain);
        cipher_keys.lcg_key    = (cipher_keys.lcg_key + {24'h0, cipher_keys.crc_key[7:0]})
                                 * 32'd134775813 + 32'd1;
        cipher_keys.stream_key = crc32_byte(cipher_keys.stream_key,
                                            cipher_keys.lcg_key[31:24]);
        return (cmd == ztsc_pkg::CMD_ENCRYPT) || (cmd == ztsc_pkg::CMD_DECRYPT);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got 0x%02h, expected 0x%02h (output byte %0d)",
                 what, got, want, n_checked);
        n_errors++;
    endtask

    // Both channels are sampled at the rising edge, where every value is still
    // the one from before the edge because all drivers use nonblocking updates.
    always @(posedge i_clk) begin
        logic [7:0] predicted;
        logic [7:0] want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                n_accepted++;
                n_by_cmd[i_cmd]++;
                if (cipher_step(i_cmd, i_data_in, predicted))
                    pending_bytes.push_back(row_lit_en ? row_lit : predicted);
            end
            if (o_valid && !i_stall) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch("unexpected output transaction", o_data_out, 8'h00);
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_data_out !== want)
                        report_mismatch("data_out", o_data_out, want);
                end
                n_checked++;
            end
        end
    end

    // Hang detector: counts cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout after %0d idle cycles", stuck_cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // Offers one transaction, optionally after a burst of idle cycles, and
    // returns at the edge where it is accepted. The payload holds while stalled.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic has_lit, input logic [7:0] lit);
        if (!quiet && tx_gappy && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_data_in  <= data;
        row_lit_en <= has_lit;
        row_lit    <= lit;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        n_sent++;
        if (n_sent >= N_ITEMS - N_QUIET_TAIL)
            quiet = 1'b1;
    endtask

    task automatic send_random(input logic [1:0] cmd);
        send_item(cmd, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
    endtask

    // Receiver: random stall bursts, one long hold-off so the block backs up
    // into its command channel, and no stalls at all once the tail is reached.
    initial begin
        bit held;
        bit rx_gappy;
        int run_left;
        held     = 1'b0;
        rx_gappy = 1'b0;
        run_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                rx_gappy = ($urandom_range(0, 99) < 60);
                run_left = $urandom_range(20, 80);
            end else begin
                run_left--;
            end
            if (!held && n_accepted >= 300) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && rx_gappy && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Sender: reset, directed table, then random sequences.
    initial begin
        bit drained;
        int pw_len;
        int burst_len;
        int kind;
        drained = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_cmd      <= ztsc_pkg::CMD_RESTART;
        i_data_in  <= 8'h00;
        row_lit_en <= 1'b0;
        row_lit    <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_gappy = 1'b1;
        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].data,
                      directed_rows[i].has_lit, directed_rows[i].lit);

        // Mostly well-formed sessions (restart, password, a run of data bytes),
        // the rest short runs of arbitrary commands.
        while (n_sent < N_ITEMS) begin
            tx_gappy = 1'($urandom_range(0, 1));
            if (!drained && n_sent >= 600) begin
                // Let the pipeline empty completely before going on.
                drained = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_bytes.size() != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                send_random(ztsc_pkg::CMD_RESTART);
                pw_len = $urandom_range(1, 12);
                repeat (pw_len) send_random(ztsc_pkg::CMD_PASSWORD);
                burst_len = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0: repeat (burst_len) send_random(ztsc_pkg::CMD_ENCRYPT);
                    1: repeat (burst_len) send_random(ztsc_pkg::CMD_DECRYPT);
                    default: repeat (burst_len) send_random(2'($urandom_range(2, 3)));
                endcase
            end else begin
                repeat ($urandom_range(1, 6)) send_random(2'($urandom_range(0, 3)));
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending_bytes.size() != 0);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d transactions: %0d restart, %0d password, %0d encrypt, %0d decrypt;",
                 n_accepted, n_by_cmd[ztsc_pkg::CMD_RESTART],
                 n_by_cmd[ztsc_pkg::CMD_PASSWORD], n_by_cmd[ztsc_pkg::CMD_ENCRYPT],
                 n_by_cmd[ztsc_pkg::CMD_DECRYPT]);
        $display("%0d output bytes compared, %0d mismatches, one long output hold-off.",
                 n_checked, n_errors);
        if (n_errors == 0 && pending_bytes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/ztsc_pkg.sv
rtl/ztsc_keystream.sv
rtl/ztsc_key_update.sv
rtl/zip_traditional_stream_cipher.sv
rtl/ztsc_checker.sv
tb/sv/tb_top.sv
